>>> hdl/pucd_pkg.sv
// Shared types and constants for the percent-unescape and UTF-8 decode block.
// Used by the escape scanner, the byte-group queue and the UTF-8 decoder.
`default_nettype none

package pucd_pkg;

  localparam int CU_W = 16;
  localparam int CP_W = 21;
  localparam int GROUP_BYTES = 3;

  localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [7:0] PERCENT = 8'h25;

  typedef struct packed {
    logic [GROUP_BYTES-1:0][7:0] bytes;
    logic [1:0] count;
    logic last;
  } byte_group_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic last;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/pucd_front.sv
// Escape scanner: resolves percent escapes and releases zero to three bytes per code unit.
// Depends on pucd_pkg for the byte-group type and constants.
`default_nettype none

module pucd_front import pucd_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire logic [CU_W-1:0] code_unit,
  input  wire logic            end_of_string,
  input  wire logic            full,
  output logic                 group_valid,
  output byte_group_t          group
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PERCENT,
    PH_DIGIT
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  held_char, held_char_next;
  logic [3:0]  held_value, held_value_next;
  logic        is_hex;
  logic [3:0]  hex_val;
  logic        plain_emit;
  logic        accept;

  always_comb begin
    is_hex  = 1'b0;
    hex_val = 4'd0;
    if (code_unit[15:8] == 8'h00) begin
      if (code_unit[7:0] >= 8'h30 && code_unit[7:0] <= 8'h39) begin
        is_hex  = 1'b1;
        hex_val = code_unit[3:0];
      end else if ((code_unit[7:0] >= 8'h41 && code_unit[7:0] <= 8'h46) ||
                   (code_unit[7:0] >= 8'h61 && code_unit[7:0] <= 8'h66)) begin
        is_hex  = 1'b1;
        hex_val = code_unit[3:0] + 4'd9;
      end
    end
  end

  assign plain_emit = !(code_unit == {8'h00, PERCENT} && !end_of_string);
  assign accept     = push && !full;

  always_comb begin
    group           = '0;
    phase_next      = phase;
    held_char_next  = held_char;
    held_value_next = held_value;
    unique case (phase)
      PH_IDLE: begin
        if (plain_emit) begin
          group.bytes[0] = code_unit[7:0];
          group.count    = 2'd1;
          phase_next     = PH_IDLE;
        end else begin
          phase_next = PH_PERCENT;
        end
      end
      PH_PERCENT: begin
        if (is_hex && !end_of_string) begin
          held_char_next  = code_unit[7:0];
          held_value_next = hex_val;
          phase_next      = PH_DIGIT;
        end else begin
          group.bytes[0] = PERCENT;
          group.bytes[1] = code_unit[7:0];
          group.count    = plain_emit ? 2'd2 : 2'd1;
          phase_next     = plain_emit ? PH_IDLE : PH_PERCENT;
        end
      end
      PH_DIGIT: begin
        if (is_hex) begin
          group.bytes[0] = {held_value, hex_val};
          group.count    = 2'd1;
          phase_next     = PH_IDLE;
        end else begin
          group.bytes[0] = PERCENT;
          group.bytes[1] = held_char;
          group.bytes[2] = code_unit[7:0];
          group.count    = plain_emit ? 2'd3 : 2'd2;
          phase_next     = plain_emit ? PH_IDLE : PH_PERCENT;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (end_of_string) begin
      phase_next = PH_IDLE;
    end
    group.last = end_of_string;
  end

  assign group_valid = accept && (group.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_char  <= 8'h00;
      held_value <= 4'h0;
    end else if (accept) begin
      phase      <= phase_next;
      held_char  <= held_char_next;
      held_value <= held_value_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pucd_group_fifo.sv
// Short queue of byte groups between the escape scanner and the UTF-8 decoder.
// Depends on pucd_pkg for the byte-group type.
`default_nettype none

module pucd_group_fifo import pucd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  input  byte_group_t       push_group,
  output logic              full,
  output byte_group_t       head,
  output logic              head_valid,
  input  wire logic         head_pop
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  byte_group_t      slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

>>> hdl/pucd_back.sv
// UTF-8 decoder with maximal-subpart replacement and the result queue behind it.
// Depends on pucd_pkg for the byte-group and result types.
`default_nettype none

module pucd_back import pucd_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  byte_group_t          head,
  input  wire logic            head_valid,
  output logic                 head_pop,
  output logic [CP_W-1:0]      code_point,
  output logic                 last_of_string,
  output logic                 empty,
  input  wire logic            pop
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

  localparam logic [2:0] BOUND_ANY = 3'd0;
  localparam logic [2:0] BOUND_E0  = 3'd1;
  localparam logic [2:0] BOUND_ED  = 3'd2;
  localparam logic [2:0] BOUND_F0  = 3'd3;
  localparam logic [2:0] BOUND_F4  = 3'd4;

  logic [1:0]      byte_idx;
  logic [1:0]      need, need_n;
  logic [1:0]      seen, seen_n, seen_inc;
  logic [2:0]      cls, cls_n;
  logic [CP_W-1:0] part, part_n;

  logic [7:0]      cur;
  logic            end_byte, last_in_group, go;
  logic [7:0]      lo, hi;
  logic            lead;
  logic            a_v, b_v, c_v;
  logic [CP_W-1:0] a_cp, b_cp;
  result_t         res [2];
  logic [1:0]      n;

  result_t          slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  assign cur           = head.bytes[byte_idx];
  assign last_in_group = (byte_idx == head.count - 2'd1);
  assign end_byte      = head.last && last_in_group;
  assign go            = head_valid && (count <= ROOM_LIMIT);
  assign head_pop      = go && last_in_group;

  always_comb begin
    need_n   = need;
    seen_n   = seen;
    cls_n    = cls;
    part_n   = part;
    a_v      = 1'b0;
    a_cp     = '0;
    b_v      = 1'b0;
    b_cp     = '0;
    c_v      = 1'b0;
    lead     = 1'b1;
    lo       = 8'h80;
    hi       = 8'hBF;
    seen_inc = seen + 2'd1;
    if (seen == 2'd0) begin
      unique case (cls)
        BOUND_E0: lo = 8'hA0;
        BOUND_ED: hi = 8'h9F;
        BOUND_F0: lo = 8'h90;
        BOUND_F4: hi = 8'h8F;
        default: ;
      endcase
    end
    if (need != 2'd0) begin
      if (cur >= lo && cur <= hi) begin
        lead = 1'b0;
        if (seen_inc >= need) begin
          a_v    = 1'b1;
          a_cp   = {part[CP_W-7:0], cur[5:0]};
          need_n = 2'd0;
          seen_n = 2'd0;
          cls_n  = BOUND_ANY;
          part_n = '0;
        end else begin
          seen_n = seen_inc;
          part_n = {part[CP_W-7:0], cur[5:0]};
        end
      end else begin
        a_v    = 1'b1;
        a_cp   = REPLACEMENT;
        need_n = 2'd0;
        seen_n = 2'd0;
        cls_n  = BOUND_ANY;
        part_n = '0;
      end
    end
    if (lead) begin
      seen_n = 2'd0;
      priority if (cur < 8'h80) begin
        b_v  = 1'b1;
        b_cp = {13'd0, cur};
      end else if (cur >= 8'hC2 && cur <= 8'hDF) begin
        need_n = 2'd1;
        cls_n  = BOUND_ANY;
        part_n = {16'd0, cur[4:0]};
      end else if (cur == 8'hE0) begin
        need_n = 2'd2;
        cls_n  = BOUND_E0;
        part_n = {17'd0, cur[3:0]};
      end else if (cur == 8'hED) begin
        need_n = 2'd2;
        cls_n  = BOUND_ED;
        part_n = {17'd0, cur[3:0]};
      end else if (cur >= 8'hE1 && cur <= 8'hEF) begin
        need_n = 2'd2;
        cls_n  = BOUND_ANY;
        part_n = {17'd0, cur[3:0]};
      end else if (cur == 8'hF0) begin
        need_n = 2'd3;
        cls_n  = BOUND_F0;
        part_n = {18'd0, cur[2:0]};
      end else if (cur == 8'hF4) begin
        need_n = 2'd3;
        cls_n  = BOUND_F4;
        part_n = {18'd0, cur[2:0]};
      end else if (cur >= 8'hF1 && cur <= 8'hF3) begin
        need_n = 2'd3;
        cls_n  = BOUND_ANY;
        part_n = {18'd0, cur[2:0]};
      end else begin
        b_v  = 1'b1;
        b_cp = REPLACEMENT;
      end
    end
    if (end_byte) begin
      c_v    = (need_n != 2'd0);
      need_n = 2'd0;
      seen_n = 2'd0;
      cls_n  = BOUND_ANY;
      part_n = '0;
    end
  end

  always_comb begin
    res[0] = '0;
    res[1] = '0;
    n      = 2'd0;
    if (a_v) begin
      res[0] = '{cp: a_cp, last: 1'b0};
      n      = 2'd1;
    end
    if (b_v) begin
      res[n[0]] = '{cp: b_cp, last: 1'b0};
      n         = n + 2'd1;
    end
    if (c_v) begin
      res[n[0]] = '{cp: REPLACEMENT, last: 1'b0};
      n         = n + 2'd1;
    end
    if (end_byte && n != 2'd0) begin
      res[1'(n - 2'd1)].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= 2'd0;
      need     <= 2'd0;
      seen     <= 2'd0;
      cls      <= BOUND_ANY;
      part     <= '0;
    end else if (go) begin
      byte_idx <= last_in_group ? 2'd0 : byte_idx + 2'd1;
      need     <= need_n;
      seen     <= seen_n;
      cls      <= cls_n;
      part     <= part_n;
    end
  end

  assign empty          = (count == '0);
  assign do_pop         = pop && !empty;
  assign code_point     = slots[rd_ptr].cp;
  assign last_of_string = slots[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (go && n != 2'd0) begin
      slots[wr_ptr] <= res[0];
    end
    if (go && n == 2'd2) begin
      slots[ptr_inc(wr_ptr)] <= res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (go && n == 2'd1) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end else if (go && n == 2'd2) begin
        wr_ptr <= ptr_inc(ptr_inc(wr_ptr));
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + (go ? CNT_W'(n) : '0) - CNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

>>> hdl/percent_unescape_utf8_replace_decode.sv
// Top level of the percent-unescape and UTF-8 replacement decoder.
// Depends on pucd_pkg, pucd_front, pucd_group_fifo and pucd_back.
//
// Code units enter through a queue-style port (push/full) and decoded code points leave
// through another (empty/pop). The escape scanner takes one code unit per cycle while
// the group queue is not full and turns it into zero to three bytes; the UTF-8 decoder
// behind a GROUP_DEPTH-entry queue consumes one byte per cycle and writes up to two code
// points into a RESULT_DEPTH-entry result queue, but waits while that queue has fewer than
// two free entries. A unit that releases several bytes is decoded one byte at a time, so
// ordinary text runs at one unit per cycle when nothing stalls. A result passes through
// the group queue and the result queue before it appears on the output.
// Every string produces at least one code point, and its final one carries last_of_string.
`default_nettype none

module percent_unescape_utf8_replace_decode import pucd_pkg::*; #(
  parameter int GROUP_DEPTH  = 4,
  parameter int RESULT_DEPTH = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [CU_W-1:0] code_unit,
  input  wire logic            end_of_string,
  output logic                 empty,
  input  wire logic            pop,
  output logic [CP_W-1:0]      code_point,
  output logic                 last_of_string
);

  byte_group_t new_group, head;
  logic        new_valid, head_valid, head_pop;

  pucd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .code_unit     (code_unit),
    .end_of_string (end_of_string),
    .full          (full),
    .group_valid   (new_valid),
    .group         (new_group)
  );

  pucd_group_fifo #(
    .DEPTH (GROUP_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (new_valid),
    .push_group (new_group),
    .full       (full),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  pucd_back #(
    .DEPTH (RESULT_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .head_valid     (head_valid),
    .head_pop       (head_pop),
    .code_point     (code_point),
    .last_of_string (last_of_string),
    .empty          (empty),
    .pop            (pop)
  );

endmodule

`default_nettype wire

>>> hdl/pucd_checker.sv
// Port-level checks for the percent-unescape and UTF-8 decoder, bound to its top level.
// Depends on pucd_pkg for field widths.
`default_nettype none

module pucd_checker import pucd_pkg::*; (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            push,
  input wire logic            full,
  input wire logic [CU_W-1:0] code_unit,
  input wire logic            end_of_string,
  input wire logic            empty,
  input wire logic            pop,
  input wire logic [CP_W-1:0] code_point,
  input wire logic            last_of_string
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_scalar_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> code_point <= 21'h10FFFF)
    else $error("code point above U+10FFFF");

  a_no_surrogate: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(code_point >= 21'h00D800 && code_point <= 21'h00DFFF))
    else $error("surrogate code point delivered");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(code_point) && $stable(last_of_string))
    else $error("waiting result changed");

endmodule

bind percent_unescape_utf8_replace_decode pucd_checker u_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for percent_unescape_utf8_replace_decode.
// Holds its own decoder model, a queue-fed driver and a checking monitor;
// depends only on pucd_pkg and the RTL.
module tb import pucd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_STEP_CPS = 4;
  localparam int DIRECTED_UNITS = 24;
  localparam int RANDOM_UNITS = 150;

  typedef enum logic [1:0] {ESC_NONE, ESC_PERCENT, ESC_DIGIT} esc_e;
  typedef enum logic [2:0] {BOUND_FULL, BOUND_E0, BOUND_ED, BOUND_F0, BOUND_F4} bound_e;

  typedef struct packed {
    logic [CU_W-1:0] unit;
    logic            eos;
  } unit_item_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            last;
  } cp_rec_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            push = 1'b0;
  logic            full;
  logic [CU_W-1:0] code_unit = '0;
  logic            end_of_string = 1'b0;
  logic            empty;
  logic            pop = 1'b0;
  logic [CP_W-1:0] code_point;
  logic            last_of_string;

  unit_item_t      units_to_send[$];
  cp_rec_t         cps_awaited[$];
  logic [CP_W-1:0] step_cps[$];

  esc_e            esc;
  logic [7:0]      held_char;
  logic [3:0]      held_val;
  logic [1:0]      need;
  logic [1:0]      seen;
  bound_e          bound_cls;
  logic [CP_W-1:0] partial;

  logic            unit_taken = 1'b0;
  logic            calm = 1'b0;
  int              send_gap = 0;
  int              stall_left = 0;
  int              calm_cycles = 0;
  int              fail_count = 0;
  cp_rec_t         got_rec;

  percent_unescape_utf8_replace_decode i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .code_unit      (code_unit),
    .end_of_string  (end_of_string),
    .empty          (empty),
    .pop            (pop),
    .code_point     (code_point),
    .last_of_string (last_of_string)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int hex_val(logic [CU_W-1:0] u);
    if (u >= 16'h30 && u <= 16'h39) return int'(u) - 'h30;
    if (u >= 16'h41 && u <= 16'h46) return int'(u) - 'h41 + 10;
    if (u >= 16'h61 && u <= 16'h66) return int'(u) - 'h61 + 10;
    return -1;
  endfunction

  function void emit(logic [CP_W-1:0] cp);
    if (step_cps.size() < MAX_STEP_CPS) step_cps.push_back(cp);
  endfunction

  function void close_seq();
    need = '0;
    seen = '0;
    bound_cls = BOUND_FULL;
    partial = '0;
  endfunction

  function void open_seq(logic [1:0] n, bound_e c, logic [CP_W-1:0] bits);
    need = n;
    seen = '0;
    bound_cls = c;
    partial = bits;
  endfunction

  function void utf8_byte(logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (need != 0) begin
      if (seen == 0) begin
        case (bound_cls)
          BOUND_E0: lo = 8'hA0;
          BOUND_ED: hi = 8'h9F;
          BOUND_F0: lo = 8'h90;
          BOUND_F4: hi = 8'h8F;
          default: ;
        endcase
      end
      if (b >= lo && b <= hi) begin
        partial = {partial[CP_W-7:0], b[5:0]};
        seen = seen + 2'd1;
        if (seen >= need) begin
          emit(partial);
          close_seq();
        end
        return;
      end
      emit(REPLACEMENT);
      close_seq();
    end
    if (b < 8'h80) emit({13'd0, b});
    else if (b >= 8'hC2 && b <= 8'hDF) open_seq(2'd1, BOUND_FULL, {16'd0, b[4:0]});
    else if (b == 8'hE0) open_seq(2'd2, BOUND_E0, {17'd0, b[3:0]});
    else if (b == 8'hED) open_seq(2'd2, BOUND_ED, {17'd0, b[3:0]});
    else if (b >= 8'hE1 && b <= 8'hEF) open_seq(2'd2, BOUND_FULL, {17'd0, b[3:0]});
    else if (b == 8'hF0) open_seq(2'd3, BOUND_F0, {18'd0, b[2:0]});
    else if (b == 8'hF4) open_seq(2'd3, BOUND_F4, {18'd0, b[2:0]});
    else if (b >= 8'hF1 && b <= 8'hF3) open_seq(2'd3, BOUND_FULL, {18'd0, b[2:0]});
    else emit(REPLACEMENT);
  endfunction

  function void scan_plain(logic [CU_W-1:0] u, logic eos);
    if (u == {8'd0, PERCENT} && !eos) begin
      esc = ESC_PERCENT;
    end else begin
      esc = ESC_NONE;
      utf8_byte(u[7:0]);
    end
  endfunction

  function void clear_decoder();
    esc = ESC_NONE;
    held_char = '0;
    held_val = '0;
    close_seq();
  endfunction

  function void decode_unit(logic [CU_W-1:0] u, logic eos);
    int      h;
    cp_rec_t rec;
    h = hex_val(u);
    step_cps.delete();
    case (esc)
      ESC_PERCENT: begin
        if (h >= 0 && !eos) begin
          held_char = u[7:0];
          held_val = h[3:0];
          esc = ESC_DIGIT;
        end else begin
          esc = ESC_NONE;
          utf8_byte(PERCENT);
          scan_plain(u, eos);
        end
      end
      ESC_DIGIT: begin
        esc = ESC_NONE;
        if (h >= 0) begin
          utf8_byte({held_val, h[3:0]});
        end else begin
          utf8_byte(PERCENT);
          utf8_byte(held_char);
          scan_plain(u, eos);
        end
      end
      default: scan_plain(u, eos);
    endcase
    if (eos) begin
      if (need != 0) emit(REPLACEMENT);
      clear_decoder();
    end
    foreach (step_cps[k]) begin
      rec.cp = step_cps[k];
      rec.last = eos && (k == step_cps.size() - 1);
      cps_awaited.push_back(rec);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function void add_unit(logic [CU_W-1:0] u, logic eos);
    unit_item_t t;
    t.unit = u;
    t.eos = eos;
    units_to_send.push_back(t);
  endfunction

  function void mark_string_end();
    unit_item_t t;
    t = units_to_send.pop_back();
    t.eos = 1'b1;
    units_to_send.push_back(t);
  endfunction

  function automatic logic [CU_W-1:0] hex_char(logic [3:0] v, bit lower);
    if (v < 4'd10) return 16'h30 + v;
    return (lower ? 16'h61 : 16'h41) + v - 16'd10;
  endfunction

  function void add_byte(logic [7:0] b);
    logic [7:0] upper;
    if ($urandom_range(0, 2) != 0) begin
      add_unit({8'd0, PERCENT}, 1'b0);
      add_unit(hex_char(b[7:4], 1'($urandom_range(0, 1))), 1'b0);
      add_unit(hex_char(b[3:0], 1'($urandom_range(0, 1))), 1'b0);
    end else begin
      upper = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      add_unit({upper, b}, 1'b0);
    end
  endfunction

  function void add_code_point(bit damage);
    logic [CP_W-1:0] cp;
    logic [7:0]      seq[4];
    int              len;
    len = $urandom_range(1, 4);
    case (len)
      1: begin
        cp = CP_W'($urandom_range(0, 'h7F));
        seq[0] = cp[7:0];
      end
      2: begin
        cp = CP_W'($urandom_range('h80, 'h7FF));
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        cp = CP_W'($urandom_range('h800, 'hFFFF));
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        cp = CP_W'($urandom_range('h10000, 'h10FFFF));
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    if (damage && len > 1) begin
      if ($urandom_range(0, 1) == 0) len = len - 1;
      else seq[1] = 8'($urandom_range(0, 255));
    end
    for (int i = 0; i < len; i++) add_byte(seq[i]);
  endfunction

  function void add_random_string();
    int start_size;
    int tokens;
    int r;
    start_size = units_to_send.size();
    tokens = $urandom_range(1, 6);
    for (int i = 0; i < tokens; i++) begin
      r = $urandom_range(0, 9);
      case (r)
        5: add_unit(16'($urandom_range(32, 126)), 1'b0);
        6: add_unit(16'($urandom), 1'b0);
        7: add_code_point(1'b1);
        8: begin
          add_unit({8'd0, PERCENT}, 1'b0);
          if ($urandom_range(0, 1) == 0) add_unit(hex_char(4'($urandom), 1'b0), 1'b0);
          add_unit(16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 127)), 1'b0);
        end
        9: add_byte(8'($urandom_range(0, 255)));
        default: add_code_point(1'b0);
      endcase
    end
    if (units_to_send.size() == start_size) add_unit(16'($urandom), 1'b0);
    mark_string_end();
  endfunction

  function void add_directed();
    add_unit(16'h0000, 1'b0);
    add_unit(16'hFFFF, 1'b0);
    add_unit(16'h0041, 1'b1);
    add_unit(16'h0025, 1'b0);
    add_unit(16'h0047, 1'b0);
    add_unit(16'h0025, 1'b0);
    add_unit(16'h0034, 1'b0);
    add_unit(16'h007A, 1'b1);
    add_unit(16'h0025, 1'b0);
    add_unit(16'h0065, 1'b0);
    add_unit(16'h0039, 1'b1);
    add_unit(16'h01C3, 1'b0);
    add_unit(16'h0025, 1'b0);
    add_unit(16'h0061, 1'b0);
    add_unit(16'h0039, 1'b1);
    add_unit(16'h0025, 1'b1);
    add_unit(16'h0025, 1'b0);
    add_unit(16'h0034, 1'b1);
    add_unit(16'h00F0, 1'b0);
    add_unit(16'h019F, 1'b0);
    add_unit(16'h008F, 1'b0);
    add_unit(16'h02BF, 1'b1);
    add_unit(16'h00ED, 1'b0);
    add_unit(16'h00A0, 1'b1);
  endfunction

  always @(negedge clk) begin
    if (calm_cycles == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_cycles = $urandom_range(50, 150);
    end else begin
      calm_cycles--;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (unit_taken) begin
        units_to_send.delete(0);
        send_gap = pick_gap();
      end
      if (!(push && !unit_taken)) begin
        if (send_gap > 0) begin
          push <= 1'b0;
          send_gap--;
        end else if (units_to_send.size() != 0) begin
          push <= 1'b1;
          code_unit <= units_to_send[0].unit;
          end_of_string <= units_to_send[0].eos;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      unit_taken <= 1'b0;
      clear_decoder();
    end else begin
      unit_taken <= push && !full;
      if (push && !full) decode_unit(code_unit, end_of_string);
      if (pop && !empty) begin
        if (cps_awaited.size() == 0) begin
          $display("%0t: unexpected code_point %h last_of_string %b",
                   $time, code_point, last_of_string);
          fail_count++;
        end else begin
          got_rec = cps_awaited.pop_front();
          if (code_point !== got_rec.cp) begin
            $display("%0t: code_point expected %h, actual %h", $time, got_rec.cp, code_point);
            fail_count++;
          end
          if (last_of_string !== got_rec.last) begin
            $display("%0t: last_of_string expected %b, actual %b",
                     $time, got_rec.last, last_of_string);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    add_directed();
    while (units_to_send.size() < DIRECTED_UNITS + RANDOM_UNITS) add_random_string();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    while (units_to_send.size() != 0 || cps_awaited.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("** percent_unescape_utf8_replace_decode: PASSED **");
    end else begin
      $display("** percent_unescape_utf8_replace_decode: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("%0t: timeout", $time);
    $display("** percent_unescape_utf8_replace_decode: FAILED **");
    $finish;
  end

endmodule
